### hdl/mbp_pkg.sv
// mbp_pkg: shared constants, register map and the result-group record for
// the MSB bit packer. No dependencies.
package mbp_pkg;

    localparam int WORD_BITS_DEF = 16;  // default input word width
    localparam int OUT_W         = 16;  // packed_value width
    localparam int BYTE_W        = 8;   // byte-mode lane width
    localparam int DROP_W        = 5;   // dropped_bits register width
    localparam int ADDR_W        = 3;   // APB byte address width
    localparam int DATA_W        = 32;  // APB data width

    // register index, taken from paddr[2]
    localparam logic REG_DROPPED = 1'b0;
    localparam logic REG_BYTE    = 1'b1;

    // up to two packed words produced by one input word
    typedef struct packed {
        logic [OUT_W-1:0] word0;
        logic [OUT_W-1:0] word1;
        logic [1:0]       nwords;     // 1 or 2 when the group is valid
        logic             last;       // final result of the group carries tlast
        logic             byte_mode;  // split each word into low and high byte
    } mbp_group_t;

endpackage

### hdl/mbp_pack.sv
// mbp_pack: input register, bit accumulator and the shift/merge logic that
// turns one input word into a group of finished words. Uses mbp_pkg.
module mbp_pack #(
    parameter int WORD_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [WORD_BITS-1:0]       pixel_word,
    input  logic                       last_pixel,
    input  logic [mbp_pkg::DROP_W-1:0] dropped_bits,
    input  logic                       byte_output,
    output mbp_pkg::mbp_group_t        grp,
    output logic                       grp_valid,
    input  logic                       grp_ready
);
    import mbp_pkg::*;

    localparam int AW = 2 * WORD_BITS - 1;        // accumulator width
    localparam int FW = $clog2(WORD_BITS);        // fill count, always < WORD_BITS
    localparam int KW = $clog2(WORD_BITS + 1);    // kept bit count, up to WORD_BITS
    localparam int SW = $clog2(2 * WORD_BITS);    // fill + kept
    localparam logic [5:0]    W6 = 6'(WORD_BITS);
    localparam logic [SW-1:0] WS = SW'(WORD_BITS);

    logic                 in_valid_reg;
    logic [WORD_BITS-1:0] pix_reg;
    logic                 last_reg;
    logic [AW-1:0]        acc_reg, acc_next;
    logic [FW-1:0]        fill_reg, fill_next;

    logic [5:0]           drop_ext, drop_clip, kept6;
    logic [KW-1:0]        kept;
    logic [WORD_BITS-1:0] rev, keep_mask;
    logic [AW-1:0]        merged, rem;
    logic [SW-1:0]        total, rem_cnt;
    logic                 full, tail;
    logic [31:0]          head_z, tail_z;
    logic                 advance;

    // kept bits, MSB first, land at increasing stream positions
    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            rev[i] = pix_reg[WORD_BITS-1-i];
        end
    end

    always_comb
    begin
        drop_ext  = {1'b0, dropped_bits};
        drop_clip = (drop_ext > W6) ? W6 : drop_ext;
        kept6     = W6 - drop_clip;
        kept      = KW'(kept6);
        keep_mask = ~({WORD_BITS{1'b1}} << kept);
        merged    = acc_reg | (AW'(rev & keep_mask) << fill_reg);
        total     = SW'(fill_reg) + SW'(kept);
        full      = (total >= WS);
        rem       = full ? (merged >> WORD_BITS) : merged;
        rem_cnt   = full ? (total - WS) : total;
        tail      = last_reg && (rem_cnt != '0);
        head_z    = 32'(merged[WORD_BITS-1:0]);
        tail_z    = 32'(rem[WORD_BITS-1:0]);

        grp.word0     = full ? head_z[OUT_W-1:0] : tail_z[OUT_W-1:0];
        grp.word1     = tail_z[OUT_W-1:0];
        grp.nwords    = {1'b0, full} + {1'b0, tail};
        grp.last      = last_reg;
        grp.byte_mode = byte_output;
        grp_valid     = in_valid_reg && (full || tail);

        if (last_reg)
        begin
            acc_next  = '0;
            fill_next = '0;
        end
        else
        begin
            acc_next  = rem;
            fill_next = FW'(rem_cnt);
        end
    end

    // an item with no finished word never waits on the output side
    assign advance  = in_valid_reg && (grp_ready || !(full || tail));
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            acc_reg      <= '0;
            fill_reg     <= '0;
        end
        else
        begin
            if (advance)
            begin
                acc_reg  <= acc_next;
                fill_reg <= fill_next;
            end
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            pix_reg  <= pixel_word;
            last_reg <= last_pixel;
        end
    end

endmodule

### hdl/mbp_emit.sv
// mbp_emit: result register holding one word group and the sequencer that
// sends it out as words or bytes, one result per cycle unless stalled. Uses mbp_pkg.
module mbp_emit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mbp_pkg::mbp_group_t       grp,
    input  logic                      grp_valid,
    output logic                      grp_ready,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [mbp_pkg::OUT_W-1:0] m_axis_tdata,
    output logic                      m_axis_tlast
);
    import mbp_pkg::*;

    mbp_group_t       grp_reg;
    logic             valid_reg;
    logic [1:0]       idx_reg;
    logic [2:0]       n_res;
    logic             final_res;
    logic [OUT_W-1:0] word_sel;
    logic             hi_half;

    always_comb
    begin
        n_res     = grp_reg.byte_mode ? {grp_reg.nwords, 1'b0} : {1'b0, grp_reg.nwords};
        final_res = ({1'b0, idx_reg} == (n_res - 3'd1));
        if (grp_reg.byte_mode)
        begin
            word_sel = idx_reg[1] ? grp_reg.word1 : grp_reg.word0;
            hi_half  = idx_reg[0];
        end
        else
        begin
            word_sel = idx_reg[0] ? grp_reg.word1 : grp_reg.word0;
            hi_half  = 1'b0;
        end
        if (grp_reg.byte_mode)
        begin
            m_axis_tdata = hi_half ? {{(OUT_W-BYTE_W){1'b0}}, word_sel[OUT_W-1:BYTE_W]}
                                   : {{(OUT_W-BYTE_W){1'b0}}, word_sel[BYTE_W-1:0]};
        end
        else
        begin
            m_axis_tdata = word_sel;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tlast  = grp_reg.last && final_res;
    assign grp_ready     = !valid_reg || (m_axis_tready && final_res);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (grp_ready)
        begin
            valid_reg <= grp_valid;
            idx_reg   <= '0;
        end
        else if (m_axis_tready)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (grp_ready && grp_valid)
        begin
            grp_reg <= grp;
        end
    end

endmodule

### hdl/msb_bit_packer_top.sv
// msb_bit_packer_top: APB register block and the pack/emit pipeline of the
// MSB bit packer. Depends on mbp_pkg, mbp_pack and mbp_emit.
//
// Each input word loses its dropped_bits low bits (values above WORD_BITS
// drop the whole word); the remaining bits join a bit stream MSB first, and
// stream bit n becomes bit n mod WORD_BITS of output word n / WORD_BITS. A
// word goes out as soon as it is full; a request with tlast set flushes the
// partial word zero-padded and restarts the stream, and the final result it
// causes carries tlast (a flush with nothing pending gives no result). In
// byte mode each word leaves as low byte then high byte in tdata[7:0].
// Timing: a request is registered on acceptance and packed combinationally;
// the result register takes the group once it is free and offers its first
// result right away. The input side takes one request per cycle as long as
// each request gives at most one result and the output is ready; the output
// port moves one result per cycle while tready is high, so a request that
// yields more than one result (up to two words, four in byte mode) holds the
// output until its last result leaves and the input side waits behind it.
// tready on the input follows tready on the output combinationally. Registers:
// 0x0 dropped_bits[4:0], 0x4 byte_output[0]; write them only while idle.
module msb_bit_packer_top #(
    parameter int WORD_BITS = mbp_pkg::WORD_BITS_DEF,
    parameter int IN_TDATA_W = ((WORD_BITS + 7) / 8) * 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // APB configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mbp_pkg::ADDR_W-1:0] paddr,
    input  logic [mbp_pkg::DATA_W-1:0] pwdata,
    output logic [mbp_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    // input stream
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [IN_TDATA_W-1:0]      s_axis_tdata,   // [WORD_BITS-1:0] pixel_word
    input  logic                       s_axis_tlast,   // last_pixel
    // output stream
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [mbp_pkg::OUT_W-1:0]  m_axis_tdata,   // [15:0] packed_value
    output logic                       m_axis_tlast    // last_out
);
    import mbp_pkg::*;

    logic [DROP_W-1:0] dropped_bits_reg;
    logic              byte_output_reg;
    logic              wr_en;
    logic              reg_sel;
    mbp_group_t        grp;
    logic              grp_valid;
    logic              grp_ready;

    // registers on word addresses; paddr[2] picks the register
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dropped_bits_reg <= '0;
            byte_output_reg  <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_DROPPED: dropped_bits_reg <= pwdata[DROP_W-1:0];
                REG_BYTE:    byte_output_reg  <= pwdata[0];
                default:     dropped_bits_reg <= dropped_bits_reg;
            endcase
        end
    end

    // readback; misaligned addresses read zero
    always_comb
    begin
        prdata = '0;
        if (paddr[1:0] == 2'b00)
        begin
            unique case (reg_sel)
                REG_DROPPED: prdata = DATA_W'(dropped_bits_reg);
                REG_BYTE:    prdata = DATA_W'(byte_output_reg);
                default:     prdata = '0;
            endcase
        end
    end

    mbp_pack #(
        .WORD_BITS (WORD_BITS)
    ) u_pack (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .pixel_word   (s_axis_tdata[WORD_BITS-1:0]),
        .last_pixel   (s_axis_tlast),
        .dropped_bits (dropped_bits_reg),
        .byte_output  (byte_output_reg),
        .grp          (grp),
        .grp_valid    (grp_valid),
        .grp_ready    (grp_ready)
    );

    mbp_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .grp           (grp),
        .grp_valid     (grp_valid),
        .grp_ready     (grp_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

### hdl/mbp_checker.sv
// mbp_checker: port-level assertions for msb_bit_packer_top, bound to the
// top level below. Uses mbp_pkg.
module mbp_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [mbp_pkg::OUT_W-1:0] m_axis_tdata,
    input logic                      m_axis_tlast
);
    import mbp_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // input side only backs up behind a pending result
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with output idle");

    // a new burst of results comes from a request passed on by the input and result registers
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without a matching request");

    // nothing is offered right after reset
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("output valid out of reset");

endmodule

bind msb_bit_packer_top mbp_checker u_mbp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

### dv/tb_msb_bit_packer_top.sv
// tb_msb_bit_packer_top: self-checking bench for the MSB bit packer, with a
// scoreboard class that predicts the packed stream. Depends on mbp_pkg and
// msb_bit_packer_top.
`timescale 1ns / 100ps

typedef struct packed {
    logic [mbp_pkg::OUT_W-1:0] value;
    logic                      last;
} packed_result_t;

// Bit-stream predictor plus in-order compare of packed results.
class pack_checker;
    localparam int W  = mbp_pkg::WORD_BITS_DEF;
    localparam int BW = mbp_pkg::BYTE_W;

    logic [mbp_pkg::DROP_W-1:0] drop_cfg;
    logic                       byte_cfg;
    logic [2*W-2:0]             stream_bits;  // oldest bit in bit 0
    int                         fill;
    packed_result_t             expected_q[$];
    int                         errors;
    int                         requests;
    int                         results;

    function new();
        drop_cfg    = '0;
        byte_cfg    = 1'b0;
        stream_bits = '0;
        fill        = 0;
        errors      = 0;
        requests    = 0;
        results     = 0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void queue_word(logic [W-1:0] word, logic fin);
        packed_result_t r;
        if (byte_cfg)
        begin
            r.value = {{(W-BW){1'b0}}, word[BW-1:0]};
            r.last  = 1'b0;
            expected_q.push_back(r);
            r.value = {{(W-BW){1'b0}}, word[W-1:BW]};
            r.last  = fin;
            expected_q.push_back(r);
        end
        else
        begin
            r.value = word;
            r.last  = fin;
            expected_q.push_back(r);
        end
    endfunction

    function void pack_pixel(logic [W-1:0] pix, logic last);
        int kept;
        int i;
        requests++;
        // drop counts past the word width keep nothing
        kept = (drop_cfg > W) ? 0 : W - drop_cfg;
        for (i = 0; i < kept; i++)
            stream_bits[fill + i] = pix[W - 1 - i];
        fill += kept;
        if (fill >= W)
        begin
            queue_word(stream_bits[W-1:0], last && (fill == W));
            stream_bits = stream_bits >> W;
            fill -= W;
        end
        if (last)
        begin
            if (fill > 0)
                queue_word(stream_bits[W-1:0], 1'b1);
            stream_bits = '0;
            fill        = 0;
        end
    endfunction

    function void match_packed(logic [W-1:0] value, logic last);
        packed_result_t exp_r;
        results++;
        if (expected_q.size() == 0)
        begin
            $error("unexpected result: packed_value=%h last_out=%b", value, last);
            errors++;
            return;
        end
        exp_r = expected_q.pop_front();
        if (value !== exp_r.value)
        begin
            $error("packed_value mismatch: expected %h, got %h", exp_r.value, value);
            errors++;
        end
        if (last !== exp_r.last)
        begin
            $error("last_out mismatch: expected %b, got %b", exp_r.last, last);
            errors++;
        end
    endfunction

    function void flag_leftover();
        if (expected_q.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_q.size());
            errors += expected_q.size();
        end
    endfunction
endclass

module tb_msb_bit_packer_top;
    import mbp_pkg::*;

    localparam int W             = WORD_BITS_DEF;
    localparam int HOLD_CYCLES   = 200;   // long output back-pressure stretch
    localparam int SETTLE_CYCLES = 8;     // covers requests that give no result
    localparam int DRAIN_LIMIT   = 20000;
    localparam logic [ADDR_W-1:0] ADDR_DROPPED = {REG_DROPPED, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_BYTE    = {REG_BYTE, 2'b00};

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [W-1:0]      s_axis_tdata;   // [15:0] pixel_word
    logic              s_axis_tlast;   // last_pixel
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;   // [15:0] packed_value
    logic              m_axis_tlast;   // last_out

    pack_checker chk = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req      = 1'b0;   // raised by the stimulus, cleared by the receiver
    int reg_writes    = 0;
    int byte_frames   = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    msb_bit_packer_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Hard stop in case the pipeline wedges.
    initial
    begin
        #400000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Sample both handshakes at the rising edge. Results always trail their
    // request via the input and result registers, so the order of the two calls is free.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                chk.match_packed(m_axis_tdata, m_axis_tlast);
            if (s_axis_tvalid && s_axis_tready)
                chk.pack_pixel(s_axis_tdata, s_axis_tlast);
        end
    end

    // Output side: random stalls, plus one long hold-off when asked, counted
    // here so the sender keeps offering requests meanwhile.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Called and returns at a falling edge. Setup cycle, then access cycle;
    // the register takes the value at the end of the access cycle. The bus
    // then idles so back-to-back writes start from a quiet bus.
    task automatic write_reg(input logic idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= (idx == REG_DROPPED) ? ADDR_DROPPED : ADDR_BYTE;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_DROPPED)
            chk.drop_cfg = value[DROP_W-1:0];
        else
            chk.byte_cfg = value[0];
        reg_writes++;
        @(negedge clk);
    endtask

    task automatic set_mode(input int drop, input bit byte_mode);
        write_reg(REG_DROPPED, drop);
        write_reg(REG_BYTE, DATA_W'(byte_mode));
    endtask

    // Offer one request, with random idle cycles ahead of it; called and
    // returns at a falling edge, tvalid left high for a back-to-back request.
    task automatic send_pixel(input logic [W-1:0] pix, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stop offering, wait for every expected result, then let the pipeline
    // empty out before registers are touched.
    task automatic drain;
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (chk.pending() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [W-1:0] rand_pixel();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return W'($urandom_range(0, (1 << W) - 1));
        endcase
    endfunction

    // Mostly whole frames ending in tlast, with a few frames whose tlast is
    // scrambled; registers are rewritten between groups of frames, which can
    // leave a partial word in flight across the change.
    task automatic random_phase(input int n_items, input int s_idle, input int r_idle);
        int sent;
        int frame_len;
        int k;
        logic last;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(3) == 0)
            begin
                drain();
                set_mode(($urandom_range(4) == 0) ? $urandom_range(17, 31)
                                                  : $urandom_range(0, W),
                         1'($urandom_range(1)));
            end
            frame_len = $urandom_range(1, 12);
            if (chk.byte_cfg)
                byte_frames++;
            for (k = 0; k < frame_len && sent < n_items; k++)
            begin
                last = (k == frame_len - 1);
                if ($urandom_range(9) == 0)
                    last = 1'($urandom_range(1));
                send_pixel(rand_pixel(), last);
                sent++;
            end
        end
        drain();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: whole words at reset settings, all ones / all zeros.
        set_mode(0, 1'b0);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'h8001, 1'b0);
        send_pixel(16'hA5C3, 1'b1);
        drain();
        // Full drop: nothing kept, tlast with an empty stream gives nothing.
        set_mode(W, 1'b0);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'h1234, 1'b1);
        drain();
        // Drop count past the word width behaves as a full drop.
        set_mode(31, 1'b0);
        send_pixel(16'hFFFF, 1'b1);
        drain();
        // Byte mode, 12-bit pieces straddling word boundaries.
        set_mode(4, 1'b1);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'h0001, 1'b0);
        send_pixel(16'hF0F0, 1'b0);
        send_pixel(16'h8000, 1'b1);
        // Partial word pending across a register change: one full word plus
        // the flush, four bytes from one request.
        send_pixel(16'h1234, 1'b0);
        drain();
        write_reg(REG_DROPPED, 0);
        send_pixel(16'hFFFF, 1'b1);
        drain();
        // Single kept bit, flushed zero-padded.
        set_mode(15, 1'b0);
        send_pixel(16'h8000, 1'b0);
        send_pixel(16'h7FFF, 1'b1);
        drain();

        random_phase(150, 31, 65);
        random_phase(150, 65, 31);
        random_phase(110, 0, 0);

        // Back-pressure: output held for a long stretch while requests keep
        // coming at full rate, so the input side has to stall.
        set_mode(0, 1'b1);
        @(posedge clk);
        hold_req = 1'b1;
        @(negedge clk);
        repeat (40) send_pixel(rand_pixel(), $urandom_range(7) == 0);
        send_pixel(rand_pixel(), 1'b1);
        drain();

        repeat (20) @(posedge clk);
        chk.flag_leftover();
        $display("Covered %0d requests and %0d results over %0d register writes,",
                 chk.requests, chk.results, reg_writes);
        $display("word and byte modes (%0d byte-mode frames), drop counts 0..31, long stall.",
                 byte_frames);
        if (chk.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### files.f
hdl/mbp_pkg.sv
hdl/mbp_pack.sv
hdl/mbp_emit.sv
hdl/msb_bit_packer_top.sv
hdl/mbp_checker.sv
dv/tb_msb_bit_packer_top.sv
